// File: rtl/damped_spring_anchor_force_unit_macros.svh
// Assertion macros for the damped spring anchor force unit.
// Included by the top level; no other dependencies.
`ifndef DAMPED_SPRING_ANCHOR_FORCE_UNIT_MACROS_SVH
`define DAMPED_SPRING_ANCHOR_FORCE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DSAF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DSAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DSAF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DSAF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/dsaf_pkg.sv
// Package for the damped spring anchor force unit: payload types and constants.
// No dependencies.
package dsaf_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WIDE_BITS = 38;
  localparam int SQRT_BITS = 35;
  localparam int NUM_REGS = 6;

  typedef enum logic [2:0] {
    REG_ANCHOR_X    = 3'd0,
    REG_ANCHOR_Y    = 3'd1,
    REG_ANCHOR_Z    = 3'd2,
    REG_STIFFNESS   = 3'd3,
    REG_REST_LENGTH = 3'd4,
    REG_DAMPING     = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        inverse_mass;
  } item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               applied;
  } result_t;

  typedef struct packed {
    logic [31:0] stiffness;
    logic [31:0] rest_length;
    logic [31:0] damping;
  } spring_cfg_t;
endpackage

// File: rtl/damped_spring_anchor_force_unit.sv
// Damped spring force toward a fixed anchor: fully pipelined, one transaction per cycle.
// The root and divider stages set the depth of the pipeline from the accepting edge
// to the edge that raises done.
// Throughput: one transaction every cycle, results never stall.
// Reset (rst, synchronous) clears the pipeline valid bits and loads the register defaults.
// Uses dsaf_pkg, dsaf_qmul, dsaf_sqrt, dsaf_div and the macros header.
`include "damped_spring_anchor_force_unit_macros.svh"
module damped_spring_anchor_force_unit #(
  parameter int FRAC_BITS = dsaf_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dsaf_pkg::item_t   item,
  output logic              done,
  output dsaf_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  localparam int WB  = dsaf_pkg::WIDE_BITS;
  localparam int NB  = dsaf_pkg::SQRT_BITS;
  localparam int UW  = FRAC_BITS + 2;
  localparam int SW  = WB + 1;
  localparam int QL  = FRAC_BITS + 1;
  localparam logic signed [SW+1:0] WMAX = (SW+2)'({WB{1'b1}});

  logic signed [31:0] anchor_x, anchor_y, anchor_z;
  dsaf_pkg::spring_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x        <= '0;
      anchor_y        <= '0;
      anchor_z        <= '0;
      cfg.stiffness   <= 32'd65536;
      cfg.rest_length <= 32'd655360;
      cfg.damping     <= 32'd65536;
    end else if (cfg_we) begin
      case (dsaf_pkg::reg_index_t'(cfg_index))
        dsaf_pkg::REG_ANCHOR_X:    anchor_x        <= cfg_data;
        dsaf_pkg::REG_ANCHOR_Y:    anchor_y        <= cfg_data;
        dsaf_pkg::REG_ANCHOR_Z:    anchor_z        <= cfg_data;
        dsaf_pkg::REG_STIFFNESS:   cfg.stiffness   <= cfg_data;
        dsaf_pkg::REG_REST_LENGTH: cfg.rest_length <= cfg_data;
        dsaf_pkg::REG_DAMPING:     cfg.damping     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic accept;
  assign accept = start && !busy;

  // Stage 1: offsets.
  logic               v1;
  logic signed [32:0] d1 [3];
  logic signed [31:0] vel1 [3];
  logic               zero1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= accept;
    d1[0]   <= 33'(anchor_x) - 33'(item.pos_x);
    d1[1]   <= 33'(anchor_y) - 33'(item.pos_y);
    d1[2]   <= 33'(anchor_z) - 33'(item.pos_z);
    vel1[0] <= item.vel_x;
    vel1[1] <= item.vel_y;
    vel1[2] <= item.vel_z;
    zero1   <= (item.inverse_mass == '0) || (anchor_x == item.pos_x &&
               anchor_y == item.pos_y && anchor_z == item.pos_z);
  end
  logic [31:0] inv1;
  always_ff @(posedge clk) inv1 <= item.inverse_mass;

  // Stage 2: squares. Stage 3: sum.
  logic [32:0] m1 [3];
  for (genvar i = 0; i < 3; i++) begin : g_mag
    assign m1[i] = d1[i][32] ? 33'(-d1[i]) : 33'(d1[i]);
  end
  logic [65:0] sq2 [3];
  logic [69:0] ssum3;
  localparam int XW = 2 + 32 + 3*33 + 3*32 + 3;
  logic [XW-1:0] side2, side3, side_s, side_d;
  logic [2:0]    sgn1;
  assign sgn1 = {d1[2][32], d1[1][32], d1[0][32]};
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sq2[i] <= 66'(m1[i]) * 66'(m1[i]);
    side2 <= {v1, zero1, inv1, m1[0], m1[1], m1[2], vel1[0], vel1[1], vel1[2], sgn1};
    ssum3 <= 70'(sq2[0]) + 70'(sq2[1]) + 70'(sq2[2]);
    side3 <= side2;
  end
  // side bits: [XW-1]=valid, then zero (1 bit); valid travels separately to get reset.
  logic [XW-1:0] side3_m;
  assign side3_m = side3;

  logic [NB-1:0] n_s;
  dsaf_sqrt #(.XW(XW)) u_sqrt (
    .clk(clk), .rad(ssum3), .side_in(side3_m), .root(n_s), .side_out(side_s)
  );

  // Three dividers share the side line of the first.
  logic [32:0] dm [3];
  assign dm[0] = side_s[3+96+98 -: 33];
  assign dm[1] = side_s[3+96+65 -: 33];
  assign dm[2] = side_s[3+96+32 -: 33];
  logic [QL-1:0] q [3];
  logic [NB-1:0] n_d;
  logic [NB-1:0] n_dq [3];
  dsaf_div #(.FRAC_BITS(FRAC_BITS), .XW(XW + NB)) u_div0 (
    .clk(clk), .num(dm[0]), .den(n_s == '0 ? NB'(1) : n_s),
    .side_in({side_s, n_s}), .quo(q[0]), .side_out({side_d, n_d}));
  for (genvar i = 1; i < 3; i++) begin : g_div
    logic [XW-1:0] unused_side;
    dsaf_div #(.FRAC_BITS(FRAC_BITS), .XW(XW + NB)) u_div (
      .clk(clk), .num(dm[i]), .den(n_s == '0 ? NB'(1) : n_s),
      .side_in({side_s, n_s}), .quo(q[i]), .side_out({unused_side, n_dq[i]}));
  end
  assign n_dq[0] = n_d;

  // Pipeline valid bits mirror the side line but are cleared by reset.
  localparam int LAT_A = 2 + NB + QL;
  logic [LAT_A-1:0] vpipe;
  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else vpipe <= {vpipe[LAT_A-2:0], v1};
  end

  // Stage U: signed unit vector, velocities, error term.
  logic signed [UW-1:0] u_s [3];
  logic signed [31:0]   vel_d [3];
  for (genvar i = 0; i < 3; i++) begin : g_u
    assign u_s[i] = side_d[i] ? -$signed({1'b0, q[i]}) : $signed({1'b0, q[i]});
  end
  assign vel_d[0] = side_d[3+95 -: 32];
  assign vel_d[1] = side_d[3+63 -: 32];
  assign vel_d[2] = side_d[3+31 -: 32];
  logic zero_d;
  logic [31:0] inv_d;
  assign zero_d = side_d[XW-2];
  assign inv_d  = side_d[XW-3 -: 32];

  logic signed [SW-1:0] e_c;
  logic signed [36:0]   e_raw;
  assign e_raw = $signed({2'b00, n_d}) - $signed({5'b0, cfg.rest_length});
  assign e_c   = SW'(e_raw);

  // Velocity projection products.
  logic signed [SW-1:0] pv [3];
  for (genvar i = 0; i < 3; i++) begin : g_pv
    dsaf_qmul #(.FRAC_BITS(FRAC_BITS), .AW(32), .BW(UW)) u_m (
      .clk(clk), .a(vel_d[i]), .b(u_s[i]), .p(pv[i]));
  end
  logic signed [SW-1:0] e_p1, e_p2;
  logic signed [UW-1:0] u_p1 [3], u_p2 [3];
  logic [31:0] inv_p1, inv_p2;
  logic zero_p1, zero_p2;
  always_ff @(posedge clk) begin
    e_p1 <= e_c; e_p2 <= e_p1;
    inv_p1 <= inv_d; inv_p2 <= inv_p1;
    zero_p1 <= zero_d; zero_p2 <= zero_p1;
    for (int i = 0; i < 3; i++) begin
      u_p1[i] <= u_s[i]; u_p2[i] <= u_p1[i];
    end
  end

  // Sum and clamp vp.
  logic signed [SW+1:0] vsum;
  logic signed [SW-1:0] vp3;
  assign vsum = (SW+2)'(pv[0]) + (SW+2)'(pv[1]) + (SW+2)'(pv[2]);
  logic signed [SW-1:0] e3;
  logic signed [UW-1:0] u3 [3];
  logic [31:0] inv3;
  logic zero3;
  always_ff @(posedge clk) begin
    vp3 <= (vsum > WMAX) ? SW'(WMAX) : (vsum < -WMAX) ? SW'(-WMAX) : SW'(vsum);
    e3 <= e_p2; inv3 <= inv_p2; zero3 <= zero_p2;
    for (int i = 0; i < 3; i++) u3[i] <= u_p2[i];
  end

  // k*e and C*vp.
  logic signed [SW-1:0] ke, cv;
  dsaf_qmul #(.FRAC_BITS(FRAC_BITS), .AW(33), .BW(SW)) u_ke (
    .clk(clk), .a($signed({1'b0, cfg.stiffness})), .b(e3), .p(ke));
  dsaf_qmul #(.FRAC_BITS(FRAC_BITS), .AW(33), .BW(SW)) u_cv (
    .clk(clk), .a($signed({1'b0, cfg.damping})), .b(vp3), .p(cv));
  logic signed [UW-1:0] u4a [3], u4b [3];
  logic [31:0] inv4a, inv4b;
  logic zero4a, zero4b;
  always_ff @(posedge clk) begin
    inv4a <= inv3; inv4b <= inv4a; zero4a <= zero3; zero4b <= zero4a;
    for (int i = 0; i < 3; i++) begin
      u4a[i] <= u3[i]; u4b[i] <= u4a[i];
    end
  end
  logic signed [SW+1:0] isum;
  logic signed [SW-1:0] inner5;
  assign isum = (SW+2)'(ke) - (SW+2)'(cv);
  logic signed [UW-1:0] u5 [3];
  logic [31:0] inv5;
  logic zero5;
  always_ff @(posedge clk) begin
    inner5 <= (isum > WMAX) ? SW'(WMAX) : (isum < -WMAX) ? SW'(-WMAX) : SW'(isum);
    inv5 <= inv4b; zero5 <= zero4b;
    for (int i = 0; i < 3; i++) u5[i] <= u4b[i];
  end

  // coeff = inv * inner.
  logic signed [SW-1:0] coeff;
  dsaf_qmul #(.FRAC_BITS(FRAC_BITS), .AW(33), .BW(SW)) u_co (
    .clk(clk), .a($signed({1'b0, inv5})), .b(inner5), .p(coeff));
  logic signed [UW-1:0] u6a [3], u6b [3];
  logic zero6a, zero6b;
  always_ff @(posedge clk) begin
    zero6a <= zero5; zero6b <= zero6a;
    for (int i = 0; i < 3; i++) begin
      u6a[i] <= u5[i]; u6b[i] <= u6a[i];
    end
  end

  // force = u * coeff.
  logic signed [SW-1:0] fp [3];
  for (genvar i = 0; i < 3; i++) begin : g_f
    dsaf_qmul #(.FRAC_BITS(FRAC_BITS), .AW(UW), .BW(SW)) u_f (
      .clk(clk), .a(u6b[i]), .b(coeff), .p(fp[i]));
  end
  logic zero7a, zero7b;
  always_ff @(posedge clk) begin
    zero7a <= zero6b; zero7b <= zero7a;
  end

  // Tail valid line over the arithmetic stages after the divider.
  localparam int LAT_B = 10;
  logic [LAT_B-1:0] vtail;
  always_ff @(posedge clk) begin
    if (rst) vtail <= '0;
    else vtail <= {vtail[LAT_B-2:0], vpipe[LAT_A-1]};
  end

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] x);
    if (x > SW'(32'sh7fffffff)) return 32'sh7fffffff;
    if (x < -SW'(33'sh080000000)) return 32'sh80000000;
    return x[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vtail[LAT_B-1];
    result.applied <= !zero7b;
    result.force_x <= zero7b ? '0 : sat32(fp[0]);
    result.force_y <= zero7b ? '0 : sat32(fp[1]);
    result.force_z <= zero7b ? '0 : sat32(fp[2]);
  end

  `DSAF_ASSERT_IMPL(a_never_busy, clk, rst, 1'b1, !busy)
  `DSAF_ASSERT_NEXT(a_enter_pipe, clk, rst, accept, v1)
  `DSAF_ASSERT_IMPL(a_unapplied_zero, clk, rst, done && !result.applied,
    result.force_x == '0 && result.force_y == '0 && result.force_z == '0)
endmodule

// File: rtl/dsaf_qmul.sv
// Pipelined signed fixed point multiply, truncation toward zero, saturating.
// Uses dsaf_pkg constants. One product per cycle.
module dsaf_qmul #(
  parameter int FRAC_BITS = dsaf_pkg::FRAC_BITS_DEF,
  parameter int AW = 40,
  parameter int BW = 40
) (
  input  logic                                   clk,
  input  logic signed [AW-1:0]                   a,
  input  logic signed [BW-1:0]                   b,
  output logic signed [dsaf_pkg::WIDE_BITS:0]    p
);
  localparam int PW = AW + BW;
  localparam int WB = dsaf_pkg::WIDE_BITS;
  logic [AW-1:0] ma;
  logic [BW-1:0] mb;
  logic [AW-1:0] ma_r;
  logic [BW-1:0] mb_r;
  logic          neg_r;
  logic [PW-1:0] prod;
  logic [PW-1:0] shifted;
  logic [WB-1:0] mag;

  assign ma = a[AW-1] ? AW'(-a) : AW'(a);
  assign mb = b[BW-1] ? BW'(-b) : BW'(b);

  always_ff @(posedge clk) begin
    ma_r  <= ma;
    mb_r  <= mb;
    neg_r <= a[AW-1] ^ b[BW-1];
  end

  // Exact product, then drop fraction bits and clamp.
  assign prod    = PW'(ma_r) * PW'(mb_r);
  assign shifted = prod >> FRAC_BITS;
  assign mag     = (shifted > PW'({WB{1'b1}})) ? {WB{1'b1}} : shifted[WB-1:0];

  always_ff @(posedge clk) begin
    p <= neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end
endmodule

// File: rtl/dsaf_sqrt.sv
// Pipelined floor square root, one result bit per stage, plus a bypass line.
// Uses dsaf_pkg constants.
module dsaf_sqrt #(
  parameter int XW = 8
) (
  input  logic                           clk,
  input  logic [69:0]                    rad,
  input  logic [XW-1:0]                  side_in,
  output logic [dsaf_pkg::SQRT_BITS-1:0] root,
  output logic [XW-1:0]                  side_out
);
  localparam int NB = dsaf_pkg::SQRT_BITS;
  logic [69:0]   rem_q  [NB+1];
  logic [NB-1:0] root_q [NB+1];
  logic [XW-1:0] side_q [NB+1];

  assign rem_q[0]  = rad;
  assign root_q[0] = '0;
  assign side_q[0] = side_in;

  // Restoring square root: stage s decides result bit NB-1-s.
  // Root bits sit at their final place, so (r + 2^B)^2 - r^2 = r*2^(B+1) + 4^B.
  for (genvar s = 0; s < NB; s++) begin : g_stage
    localparam int B = NB - 1 - s;
    logic [71:0] trial;
    assign trial = (72'(root_q[s]) << (B + 1)) | (72'd1 << (2 * B));
    always_ff @(posedge clk) begin
      side_q[s+1] <= side_q[s];
      if ({2'b00, rem_q[s]} >= trial) begin
        rem_q[s+1]  <= rem_q[s] - trial[69:0];
        root_q[s+1] <= root_q[s] | (NB'(1) << B);
      end else begin
        rem_q[s+1]  <= rem_q[s];
        root_q[s+1] <= root_q[s];
      end
    end
  end

  assign root     = root_q[NB];
  assign side_out = side_q[NB];
endmodule

// File: rtl/dsaf_div.sv
// Pipelined unsigned restoring divider for the unit vector, one quotient bit per stage.
// Uses dsaf_pkg constants.
module dsaf_div #(
  parameter int FRAC_BITS = dsaf_pkg::FRAC_BITS_DEF,
  parameter int XW = 8
) (
  input  logic                           clk,
  input  logic [32:0]                    num,
  input  logic [dsaf_pkg::SQRT_BITS-1:0] den,
  input  logic [XW-1:0]                  side_in,
  output logic [FRAC_BITS:0]             quo,
  output logic [XW-1:0]                  side_out
);
  // |d| <= n, so the quotient fits in FRAC_BITS+1 bits.
  localparam int QB = FRAC_BITS + 1;
  localparam int NW = 33 + FRAC_BITS;
  localparam int DW = dsaf_pkg::SQRT_BITS;
  localparam int RW = DW + 1;
  logic [NW-1:0] n_q   [QB+1];
  logic [RW-1:0] r_q   [QB+1];
  logic [DW-1:0] d_q   [QB+1];
  logic [QB-1:0] q_q   [QB+1];
  logic [XW-1:0] s_q   [QB+1];

  // Numerator is |d| << F; its top bits above the quotient bits form the start remainder.
  assign n_q[0] = NW'({num, {FRAC_BITS{1'b0}}}) << 0;
  assign r_q[0] = RW'(num >> 1);
  assign d_q[0] = den;
  assign q_q[0] = '0;
  assign s_q[0] = side_in;

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int B = QB - 1 - s;
    logic [RW:0] trial;
    assign trial = {r_q[s], n_q[s][B]};
    always_ff @(posedge clk) begin
      n_q[s+1] <= n_q[s];
      d_q[s+1] <= d_q[s];
      s_q[s+1] <= s_q[s];
      if (trial >= (RW+1)'(d_q[s])) begin
        r_q[s+1] <= RW'(trial - (RW+1)'(d_q[s]));
        q_q[s+1] <= q_q[s] | (QB'(1) << B);
      end else begin
        r_q[s+1] <= RW'(trial);
        q_q[s+1] <= q_q[s];
      end
    end
  end

  assign quo      = q_q[QB];
  assign side_out = s_q[QB];
endmodule
